@@ sv/swmm_pkg.sv @@
// Shared types and constants for the sliding-window min/max/mean block.
// No dependencies; used by swmm_cell and sliding_window_min_max_mean.
`default_nettype none

package swmm_pkg;

  localparam int SAMPLE_W    = 24;  // frame time, 16.8 unsigned fixed point
  localparam int COUNT_OUT_W = 7;   // held_count field
  localparam int IN_TDATA_W  = 24;  // frame_time, no padding
  localparam int OUT_TDATA_W = 80;  // 3 x 24 + 7, padded to whole bytes

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ sv/swmm_cell.sv @@
// One storage cell of the sample chain: holds one frame time and hands it
// to the next cell on every shift. Depends on swmm_pkg.
`default_nettype none

module swmm_cell (
  input  wire               clk,
  input  wire               shift_en,
  input  wire swmm_pkg::sample_t d,
  output swmm_pkg::sample_t q
);

  swmm_pkg::sample_t sample;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= d;
    end
  end

  assign q = sample;

endmodule

`default_nettype wire

@@ sv/swmm_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by sliding_window_min_max_mean for the window mean.
`default_nettype none

module swmm_div #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire  [DIVIDEND_W-1:0] dividend,
  input  wire  [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  // The remainder stays below the divisor, so DIVISOR_W bits hold it.
  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

@@ sv/sliding_window_min_max_mean.sv @@
// Sliding-window frame-time statistics: a chain of sample cells, a scan
// unit for min/max and a serial divider for the mean.
// Depends on swmm_pkg, swmm_cell and swmm_div.
//
//  channel  | dir | bits | fields (low bit first)
//  ---------+-----+------+--------------------------------------------------
//  s_axis   | in  | 24   | frame_time[23:0]
//  m_axis   | out | 80   | mean_time[23:0] min_time[47:24] max_time[71:48]
//           |     |      | held_count[78:72], bit 79 zero
//
// One transaction is handled at a time. Acceptance shifts the sample into
// the chain and updates the running sum; then the chain rotates once
// through all WINDOW cells while the tail cell feeds the min/max compare,
// and the divider runs 24+clog2(WINDOW) steps in parallel. The finished
// result sits in the output register, so a new input is taken while it
// waits; a stalled output holds the next result back in ST_FINISH, and no
// further input is taken until that result is loaded.
// Reset (rst, synchronous) empties the window; cell contents need no reset.
`default_nettype none

module sliding_window_min_max_mean #(
  parameter int WINDOW = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [swmm_pkg::IN_TDATA_W-1:0]    s_tdata,  // frame_time[23:0]
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // mean_time[23:0], min_time[47:24], max_time[71:48], held_count[78:72]
  output logic [swmm_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int SAMPLE_W = swmm_pkg::SAMPLE_W;
  localparam int CNT_OW   = swmm_pkg::COUNT_OUT_W;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int PAD_W    = swmm_pkg::OUT_TDATA_W - 3 * SAMPLE_W - CNT_OW;

  swmm_pkg::state_t  state, state_next;

  logic [CNT_W-1:0]  fill_count;
  logic [SUM_W-1:0]  running_sum;
  logic [IDX_W-1:0]  scan_idx;
  swmm_pkg::sample_t lo, hi;

  swmm_pkg::sample_t mean_r, min_r, max_r;
  logic [CNT_OW-1:0] count_r;

  logic              accept;
  logic              shift_en;
  logic              div_start;
  logic              out_free;
  logic              out_load;
  logic              full;
  logic              tail_valid;
  logic [IDX_W-1:0]  tail_pos;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [CNT_W+CNT_OW-1:0] count_ext;

  swmm_pkg::sample_t sample;
  swmm_pkg::sample_t cell_d [WINDOW];
  swmm_pkg::sample_t cell_q [WINDOW];
  swmm_pkg::sample_t tail;

  assign sample = s_tdata[SAMPLE_W-1:0];
  assign tail   = cell_q[WINDOW-1];
  assign full   = (fill_count == CNT_W'(WINDOW));

  // Cell 0 takes the new sample on insert and the tail while rotating.
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        assign cell_d[gi] = (state == swmm_pkg::ST_IDLE) ? sample : tail;
      end else begin : g_body
        assign cell_d[gi] = cell_q[gi-1];
      end
      swmm_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (cell_d[gi]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  swmm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Scan step k sees the cell that was at position WINDOW-1-k at its start.
  assign tail_pos   = IDX_W'(WINDOW - 1) - scan_idx;
  assign tail_valid = (CNT_W'(tail_pos) < fill_count);
  assign out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    shift_en   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      swmm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        shift_en = s_tvalid;
        if (s_tvalid) begin
          state_next = swmm_pkg::ST_SCAN;
        end
      end
      swmm_pkg::ST_SCAN: begin
        shift_en  = 1'b1;
        div_start = (scan_idx == '0);
        if (scan_idx == IDX_W'(WINDOW - 1)) begin
          state_next = swmm_pkg::ST_FINISH;
        end
      end
      swmm_pkg::ST_FINISH: begin
        if (div_done && out_free) begin
          out_load   = 1'b1;
          state_next = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Window bookkeeping: drop the tail from the sum once the window is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
      running_sum <= running_sum + SUM_W'(sample)
                     - (full ? SUM_W'(tail) : SUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (accept) begin
      scan_idx <= '0;
    end else if (state == swmm_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo <= '1;
      hi <= '0;
    end else if (state == swmm_pkg::ST_SCAN && tail_valid) begin
      if (tail < lo) begin
        lo <= tail;
      end
      if (tail > hi) begin
        hi <= tail;
      end
    end
  end

  assign count_ext = {{CNT_OW{1'b0}}, fill_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_r  <= quotient[SAMPLE_W-1:0];
      min_r   <= lo;
      max_r   <= hi;
      count_r <= count_ext[CNT_OW-1:0];
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, count_r, max_r, min_r, mean_r};

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (min_r <= max_r))
    else $error("minimum above maximum");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mean_r >= min_r && mean_r <= max_r))
    else $error("mean outside min/max range");

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == swmm_pkg::ST_SCAN && scan_idx == '0))
    else $error("scan did not start after accepted transaction");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for sliding_window_min_max_mean (64-sample window).
// Depends on swmm_pkg and the RTL under sv/. Each frame time is predicted on
// acceptance and every output transaction is checked against the predicted window.
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN = 64;

  typedef struct {
    swmm_pkg::sample_t                mean_time;
    swmm_pkg::sample_t                min_time;
    swmm_pkg::sample_t                max_time;
    logic [swmm_pkg::COUNT_OUT_W-1:0] held_count;
  } frame_stats_t;

  // Shapes of random frame-time runs
  typedef enum int {
    SEG_UNIFORM,
    SEG_TYPICAL,
    SEG_EXTREME,
    SEG_FALLING,
    SEG_RISING
  } seg_kind_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [swmm_pkg::IN_TDATA_W-1:0]  s_tdata;   // frame_time[23:0]
  logic                             m_tvalid;
  logic                             m_tready;
  // mean_time[23:0], min_time[47:24], max_time[71:48], held_count[78:72]
  logic [swmm_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Window predictor state
  swmm_pkg::sample_t win_ring [WIN];
  int                win_slot;
  int                win_fill;
  logic [29:0]       win_sum;
  int                win_wraps;

  frame_stats_t stats_due [$];
  int           fail_count;
  int           items_sent;
  int           results_seen;
  bit           idle_on;
  int           long_hold_req;

  sliding_window_min_max_mean #(
    .WINDOW(WIN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one frame time and return the statistics over the held samples
  function automatic frame_stats_t advance_window(input swmm_pkg::sample_t ft);
    frame_stats_t r;
    logic [29:0]  quo;
    if (win_fill == WIN) begin
      win_sum = win_sum - 30'(win_ring[win_slot]);
    end else begin
      win_fill++;
    end
    win_ring[win_slot] = ft;
    win_sum = win_sum + 30'(ft);
    if (win_slot == WIN - 1) begin
      win_slot = 0;
      win_wraps++;
    end else begin
      win_slot++;
    end
    r.min_time = win_ring[0];
    r.max_time = win_ring[0];
    for (int i = 1; i < win_fill; i++) begin
      if (win_ring[i] < r.min_time) r.min_time = win_ring[i];
      if (win_ring[i] > r.max_time) r.max_time = win_ring[i];
    end
    quo = win_sum / 30'(win_fill);
    r.mean_time  = quo[swmm_pkg::SAMPLE_W-1:0];
    r.held_count = swmm_pkg::COUNT_OUT_W'(win_fill);
    return r;
  endfunction

  function automatic swmm_pkg::sample_t pick_frame_time(input seg_kind_t kind,
                                                        input int step);
    swmm_pkg::sample_t v;
    case (kind)
      SEG_UNIFORM: v = swmm_pkg::sample_t'($urandom);
      SEG_TYPICAL: v = swmm_pkg::sample_t'($urandom_range(2000, 9000));
      SEG_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 24'hFFFFFF - swmm_pkg::sample_t'($urandom_range(0, 255));
          default: v = swmm_pkg::sample_t'($urandom_range(0, 255));
        endcase
      end
      SEG_FALLING: v = 24'hFFFFFF - swmm_pkg::sample_t'(step * 24'h030000)
                       - swmm_pkg::sample_t'($urandom_range(0, 255));
      default:     v = swmm_pkg::sample_t'(step * 24'h030000)
                       + swmm_pkg::sample_t'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    frame_stats_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        want = stats_due[0];
        stats_due.delete(0);
        check_field("mean_time", want.mean_time, m_tdata[23:0]);
        check_field("min_time", want.min_time, m_tdata[47:24]);
        check_field("max_time", want.max_time, m_tdata[71:48]);
        check_field("held_count", 24'(want.held_count), 24'(m_tdata[78:72]));
        check_field("pad bit", 24'h0, 24'(m_tdata[79]));
      end
    end
  end

  // Output side: random stall bursts plus an occasional long hold-off
  initial begin : sink_ready
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one frame time and hold it until the transaction completes
  task automatic push_frame_time(input swmm_pkg::sample_t ft);
    frame_stats_t due;
    s_tvalid <= 1'b1;
    s_tdata  <= ft;
    do @(posedge clk); while (!s_tready);
    due = advance_window(ft);
    stats_due.insert(stats_due.size(), due);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic maybe_idle_input();
    if (idle_on && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 4));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (stats_due.size() != 0);
  endtask

  task automatic test_first_frame();
    push_frame_time(24'h0010AB);
    wait_results_drained();
  endtask

  task automatic test_field_extremes();
    swmm_pkg::sample_t pattern [10];
    pattern = '{24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555, 24'h000001,
                24'hFFFFFE, 24'h800000, 24'h7FFFFF, 24'h0F0F0F, 24'hF0F0F0};
    foreach (pattern[i]) begin
      push_frame_time(pattern[i]);
      maybe_idle_input();
    end
  endtask

  // Block the output for a long stretch while frames keep arriving
  task automatic test_output_stall();
    idle_on       = 1'b0;
    long_hold_req = 400;
    repeat (8) push_frame_time(swmm_pkg::sample_t'($urandom));
    idle_on = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_window(input int n_items);
    int        sent;
    int        seg_len;
    int        step;
    seg_kind_t kind;
    sent = 0;
    while (sent < n_items) begin
      kind    = seg_kind_t'($urandom_range(0, 4));
      seg_len = $urandom_range(1, 80);
      step    = 0;
      while (step < seg_len && sent < n_items) begin
        if (sent == n_items / 2) wait_results_drained();
        // settle into full throughput for the tail of the run
        if (sent == n_items - 60) idle_on = 1'b0;
        push_frame_time(pick_frame_time(kind, step));
        maybe_idle_input();
        step++;
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    win_slot      = 0;
    win_fill      = 0;
    win_sum       = '0;
    win_wraps     = 0;
    fail_count    = 0;
    items_sent    = 0;
    results_seen  = 0;
    idle_on       = 1'b1;
    long_hold_req = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);

    test_first_frame();
    test_field_extremes();
    test_output_stall();
    test_random_window(400);

    s_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (stats_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results missing, expected 0 left", $time, stats_due.size());
    end
    $display("Summary: %0d frame times sent, %0d results checked, window wrapped %0d times,",
             items_sent, results_seen, win_wraps);
    $display("         including a 400-cycle output hold-off and a full drain mid-run.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
